[rtl/lph_pkg.sv]
// ----------------------------------------------------------------------------
// lph_pkg
// Types, codes and constants shared by the linear probe hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 32;
    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 11;
    localparam int LOG2_W      = 4;
    localparam int HASH_W      = 16;
    localparam int MIN_LOG2    = 4;
    localparam int MAX_LOG2    = 10;
    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_KEY_BYTES  = 8;
    localparam int DEF_VALUE_BITS = 32;

    // low bits of the FNV-1a 64 offset basis and prime
    localparam logic [HASH_W-1:0] FNV_BASIS_LO = 16'h2325;
    localparam logic [HASH_W-1:0] FNV_PRIME_LO = 16'h01b3;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_SPARE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_SPARE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2,
        TAG_SPARE = 2'd3
    } tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_RESOLVE
    } state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [VAL_W-1:0]   value_out;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] live_count;
    } rsp_t;

    // keep bytes up to the first zero byte and below nbytes
    function automatic logic [KEY_W-1:0] normalize_key(logic [KEY_W-1:0] k, int nbytes);
        logic [KEY_W-1:0] r;
        logic             run;
        r   = '0;
        run = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            if (b >= nbytes || k[8*b +: 8] == 8'h00)
                run = 1'b0;
            if (run)
                r[8*b +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    function automatic logic [HASH_W-1:0] fnv_step(logic [HASH_W-1:0] h, logic [7:0] b);
        logic [2*HASH_W-1:0] p;
        p = (h ^ {8'h00, b}) * FNV_PRIME_LO;
        return p[HASH_W-1:0];
    endfunction

endpackage

[rtl/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table, FNV-1a keys, linear probing, tombstones.
// ----------------------------------------------------------------------------
// Usage: a request word (kind, key, value) enters on req_valid/req_ready and
// one response word leaves on rsp_valid/rsp_ready for every request.
// cfg_valid/cfg_ready writes log2_capacity and empties the table.
// Steps: the key is hashed one byte per step up to the first zero byte, plus
// a step to see that zero byte (none for an 8-byte key), then each probed
// slot takes a registered tag/key/value memory read and a compare, then one
// resolve step; the next request is taken only after the resolve step. The
// probe loop sets the rate: one request is in flight at a time. A request
// is taken while the previous response still waits in the output register;
// a stalled receiver holds the request in the resolve step, which then
// holds off the next request.
// Reset, and every capacity write, starts a clearing pass of one tag entry
// a cycle over the whole tag memory (restarted by each capacity write); no
// request is taken during it or while a capacity write is presented.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int KEY_BYTES  = DEF_KEY_BYTES,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LOG2_W-1:0] cfg_data
);

    localparam int CAP_LOG = $clog2(CAPACITY + 1) - 1;
    localparam int AW      = CAP_LOG > MAX_LOG2 ? MAX_LOG2 : CAP_LOG;
    localparam int DEPTH   = 1 << AW;
    localparam int VW      = VALUE_BITS < VAL_W ? VALUE_BITS : VAL_W;

    logic [1:0]       tag_mem [DEPTH];
    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [VW-1:0]    val_mem [DEPTH];

    state_t             state_reg, state_next;
    logic [LOG2_W-1:0]  log2_reg, log2_next;
    logic [COUNT_W-1:0] occ_reg, occ_next;
    logic [COUNT_W-1:0] tomb_reg, tomb_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [1:0]         kind_reg, kind_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VW-1:0]      val_reg, val_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [2:0]         byte_reg, byte_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW:0]        cnt_reg, cnt_next;
    logic               tseen_reg, tseen_next;
    logic [AW-1:0]      tidx_reg, tidx_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      hit_reg, hit_next;
    logic               spot_ok_reg, spot_ok_next;
    logic               spot_tomb_reg, spot_tomb_next;
    logic [VW-1:0]      vout_reg, vout_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [1:0]       tag_rd;
    logic [KEY_W-1:0] key_rd;
    logic [VW-1:0]    val_rd;

    logic             tag_we, key_we, val_we;
    logic [AW-1:0]    waddr;
    logic [1:0]       tag_wdata;
    logic [VW-1:0]    val_wdata;

    logic [LOG2_W-1:0] lg;
    logic [AW:0]       cap_w;
    logic [AW-1:0]     mask;
    logic [7:0]        cur_byte;
    logic [HASH_W-1:0] hash_step;
    logic [COUNT_W:0]  load;
    logic [13:0]       load_x4;
    logic [13:0]       cap_x3;
    logic              tomb_new;
    logic [AW-1:0]     tidx_new;

    always_comb
    begin
        lg = log2_reg;
        if (lg < LOG2_W'(MIN_LOG2))
            lg = LOG2_W'(MIN_LOG2);
        if (lg > LOG2_W'(MAX_LOG2))
            lg = LOG2_W'(MAX_LOG2);
        if (lg > LOG2_W'(AW))
            lg = LOG2_W'(AW);
    end

    assign cap_w     = (AW+1)'(1) << lg;
    assign mask      = AW'(cap_w - (AW+1)'(1));
    assign cur_byte  = key_reg[8*byte_reg +: 8];
    assign hash_step = fnv_step(hash_reg, cur_byte);
    assign load      = (COUNT_W+1)'(occ_reg) + (COUNT_W+1)'(tomb_reg) + (COUNT_W+1)'(1);
    assign load_x4   = {14'(load)} << 2;
    assign cap_x3    = 14'(cap_w) + (14'(cap_w) << 1);

    assign req_ready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[waddr] <= tag_wdata;
        if (key_we)
            key_mem[waddr] <= key_reg;
        if (val_we)
            val_mem[waddr] <= val_wdata;
        tag_rd <= tag_mem[idx_reg];
        key_rd <= key_mem[idx_reg];
        val_rd <= val_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            log2_reg      <= LOG2_W'(MIN_LOG2);
            occ_reg       <= '0;
            tomb_reg      <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            log2_reg      <= log2_next;
            occ_reg       <= occ_next;
            tomb_reg      <= tomb_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        hash_reg      <= hash_next;
        byte_reg      <= byte_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        tseen_reg     <= tseen_next;
        tidx_reg      <= tidx_next;
        found_reg     <= found_next;
        hit_reg       <= hit_next;
        spot_ok_reg   <= spot_ok_next;
        spot_tomb_reg <= spot_tomb_next;
        vout_reg      <= vout_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        log2_next      = log2_reg;
        occ_next       = occ_reg;
        tomb_next      = tomb_reg;
        clr_next       = clr_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        hash_next      = hash_reg;
        byte_next      = byte_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        tseen_next     = tseen_reg;
        tidx_next      = tidx_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        spot_ok_next   = spot_ok_reg;
        spot_tomb_next = spot_tomb_reg;
        vout_next      = vout_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        tag_we         = 1'b0;
        key_we         = 1'b0;
        val_we         = 1'b0;
        waddr          = hit_reg;
        tag_wdata      = TAG_EMPTY;
        val_wdata      = val_reg;
        tomb_new       = tseen_reg;
        tidx_new       = tidx_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                tag_we    = 1'b1;
                waddr     = clr_reg;
                tag_wdata = TAG_EMPTY;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req.kind;
                    key_next   = normalize_key(req.key, KEY_BYTES);
                    val_next   = req.value[VW-1:0];
                    hash_next  = FNV_BASIS_LO;
                    byte_next  = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cnt_next   = '0;
                tseen_next = 1'b0;
                if (cur_byte == 8'h00)
                begin
                    idx_next   = hash_reg[AW-1:0] & mask;
                    state_next = ST_READ;
                end
                else
                begin
                    hash_next = hash_step;
                    byte_next = byte_reg + 3'd1;
                    if (byte_reg == 3'd7)
                    begin
                        idx_next   = hash_step[AW-1:0] & mask;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (tag_rd == TAG_EMPTY)
                begin
                    found_next     = 1'b0;
                    spot_ok_next   = 1'b1;
                    spot_tomb_next = tseen_reg;
                    hit_next       = tseen_reg ? tidx_reg : idx_reg;
                    state_next     = ST_RESOLVE;
                end
                else if (tag_rd == TAG_LIVE && key_rd == key_reg)
                begin
                    found_next = 1'b1;
                    hit_next   = idx_reg;
                    vout_next  = val_rd;
                    state_next = ST_RESOLVE;
                end
                else
                begin
                    if (tag_rd == TAG_TOMB && !tseen_reg)
                    begin
                        tomb_new = 1'b1;
                        tidx_new = idx_reg;
                    end
                    tseen_next = tomb_new;
                    tidx_next  = tidx_new;
                    cnt_next   = cnt_reg + (AW+1)'(1);
                    if (cnt_next == cap_w)
                    begin
                        found_next     = 1'b0;
                        spot_ok_next   = tomb_new;
                        spot_tomb_next = 1'b1;
                        hit_next       = tidx_new;
                        state_next     = ST_RESOLVE;
                    end
                    else
                    begin
                        idx_next   = (idx_reg + AW'(1)) & mask;
                        state_next = ST_READ;
                    end
                end
            end
            ST_RESOLVE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status    = STAT_OK;
                    rsp_next.found     = found_reg;
                    rsp_next.value_out = '0;
                    rsp_next.slot      = SLOT_W'(hit_reg);
                    case (kind_reg)
                        KIND_INSERT:
                        begin
                            if (found_reg)
                            begin
                                val_we = 1'b1;
                            end
                            else if (!spot_ok_reg || load_x4 > cap_x3)
                            begin
                                rsp_next.status = STAT_FULL;
                                rsp_next.slot   = '0;
                            end
                            else
                            begin
                                tag_we    = 1'b1;
                                key_we    = 1'b1;
                                val_we    = 1'b1;
                                tag_wdata = TAG_LIVE;
                                occ_next  = occ_reg + COUNT_W'(1);
                                if (spot_tomb_reg && tomb_reg != '0)
                                    tomb_next = tomb_reg - COUNT_W'(1);
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                tag_we    = 1'b1;
                                val_we    = 1'b1;
                                tag_wdata = TAG_TOMB;
                                val_wdata = '0;
                                tomb_next = tomb_reg + COUNT_W'(1);
                                if (occ_reg != '0)
                                    occ_next = occ_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                rsp_next.status = STAT_NOT_FOUND;
                                rsp_next.slot   = '0;
                            end
                        end
                        default:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.value_out = VAL_W'(vout_reg);
                            end
                            else
                            begin
                                rsp_next.status = STAT_NOT_FOUND;
                                rsp_next.slot   = '0;
                            end
                        end
                    endcase
                    rsp_next.live_count = occ_next;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // a capacity write empties the table
        if (cfg_valid)
        begin
            log2_next  = cfg_data;
            occ_next   = '0;
            tomb_next  = '0;
            clr_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !req_ready)
        else $error("request taken during clearing pass");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg + tomb_reg) <= COUNT_W'(DEPTH))
        else $error("live plus tombstone count exceeds table size");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> cnt_reg < cap_w)
        else $error("probe ran past capacity");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == STAT_FULL |->
            !rsp_reg.found && rsp_reg.slot == '0 && rsp_reg.value_out == '0)
        else $error("full response carries data");

    a_resolve_write: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> state_reg == ST_RESOLVE && !found_reg)
        else $error("key written outside insert");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probe hash table: a local table model
// predicts each response word from every accepted request word; capacity
// changes happen only with the block idle; both sides idle at random, except in the third capacity phase.
// ----------------------------------------------------------------------------
module tb;
    import lph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WATCH_LIMIT = 20000;
    localparam int  SETTLE      = 40;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [LOG2_W-1:0] cfg_data;

    linear_probe_hash_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tag_t              tbl_tag [1024];
    logic [KEY_W-1:0]  tbl_key [1024];
    logic [VAL_W-1:0]  tbl_val [1024];
    int unsigned       n_live;
    int unsigned       n_tomb;
    logic [LOG2_W-1:0] tbl_log2;

    req_t        pending_req [$];
    rsp_t        expected_rsp [$];
    logic [KEY_W-1:0] used_keys [$];
    int          errors;
    bit          idle_on;
    bit          hold_send;
    int          watch;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void clear_tbl();
        for (int i = 0; i < 1024; i++)
            tbl_tag[i] = TAG_EMPTY;
        n_live = 0;
        n_tomb = 0;
    endfunction

    function automatic int unsigned table_slots();
        int unsigned l;
        l = tbl_log2;
        if (l < MIN_LOG2)
            l = MIN_LOG2;
        if (l > MAX_LOG2)
            l = MAX_LOG2;
        return 16 << (l - 4);
    endfunction

    function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        r = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (k[8*b +: 8] == 8'h00)
                break;
            r[8*b +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] fnv1a(logic [KEY_W-1:0] k);
        logic [63:0] h;
        h = 64'hcbf29ce484222325;
        for (int b = 0; b < 8; b++)
        begin
            if (k[8*b +: 8] == 8'h00)
                break;
            h = h ^ {56'd0, k[8*b +: 8]};
            h = h * 64'd1099511628211;
        end
        return h;
    endfunction

    function automatic rsp_t table_access(req_t r);
        rsp_t        o;
        logic [KEY_W-1:0] k;
        int unsigned cap, msk, i, hit, spot;
        bit          hit_ok, spot_ok, tomb_seen;
        int unsigned tomb;
        k = trim_key(r.key);
        cap = table_slots();
        msk = cap - 1;
        i = 32'(fnv1a(k) & 64'(msk));
        hit_ok = 0;
        spot_ok = 0;
        tomb_seen = 0;
        tomb = 0;
        hit = 0;
        spot = 0;
        for (int n = 0; n < cap; n++)
        begin
            if (tbl_tag[i] == TAG_EMPTY)
            begin
                spot_ok = 1;
                spot = tomb_seen ? tomb : i;
                break;
            end
            if (tbl_tag[i] == TAG_TOMB)
            begin
                if (!tomb_seen)
                begin
                    tomb_seen = 1;
                    tomb = i;
                end
            end
            else if (tbl_key[i] == k)
            begin
                hit_ok = 1;
                hit = i;
                break;
            end
            i = (i + 1) & msk;
        end
        if (!hit_ok && !spot_ok && tomb_seen)
        begin
            spot_ok = 1;
            spot = tomb;
        end
        o = '0;
        if (r.kind == KIND_INSERT)
        begin
            if (hit_ok)
            begin
                tbl_val[hit] = r.value;
                o.found = 1'b1;
                o.slot = SLOT_W'(hit);
            end
            else if (!spot_ok || (n_live + n_tomb + 1) * 4 > cap * 3)
                o.status = STAT_FULL;
            else
            begin
                if (tbl_tag[spot] == TAG_TOMB && n_tomb > 0)
                    n_tomb--;
                tbl_tag[spot] = TAG_LIVE;
                tbl_key[spot] = k;
                tbl_val[spot] = r.value;
                n_live++;
                o.slot = SLOT_W'(spot);
            end
        end
        else if (r.kind == KIND_REMOVE)
        begin
            if (hit_ok)
            begin
                tbl_tag[hit] = TAG_TOMB;
                tbl_val[hit] = '0;
                if (n_live > 0)
                    n_live--;
                n_tomb++;
                o.found = 1'b1;
                o.slot = SLOT_W'(hit);
            end
            else
                o.status = STAT_NOT_FOUND;
        end
        else
        begin
            if (hit_ok)
            begin
                o.found = 1'b1;
                o.value_out = tbl_val[hit];
                o.slot = SLOT_W'(hit);
            end
            else
                o.status = STAT_NOT_FOUND;
        end
        o.live_count = COUNT_W'(n_live);
        return o;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_req.size() > 0 && !hold_send &&
                !(idle_on && $urandom_range(99) < 25))
            begin
                req_valid <= 1'b1;
                req <= pending_req.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !(idle_on && $urandom_range(99) < 25);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(table_access(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response word with nothing expected");
                    errors++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsp.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, rsp.status);
                        errors++;
                    end
                    if (rsp.found !== e.found)
                    begin
                        $error("found exp %0d got %0d", e.found, rsp.found);
                        errors++;
                    end
                    if (rsp.value_out !== e.value_out)
                    begin
                        $error("value_out exp %h got %h", e.value_out, rsp.value_out);
                        errors++;
                    end
                    if (rsp.slot !== e.slot)
                    begin
                        $error("slot exp %0d got %0d", e.slot, rsp.slot);
                        errors++;
                    end
                    if (rsp.live_count !== e.live_count)
                    begin
                        $error("live_count exp %0d got %0d", e.live_count, rsp.live_count);
                        errors++;
                    end
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
                watch <= 0;
            else
                watch <= watch + 1;
        end
    end

    always @(posedge clk)
    begin
        if (watch >= WATCH_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        int nb;
        nb = $urandom_range(8, 1);
        k = {$urandom, $urandom};
        for (int b = 0; b < 8; b++)
        begin
            if (k[8*b +: 8] == 8'h00)
                k[8*b +: 8] = 8'h01 << (b % 8);
            if (b >= nb)
                k[8*b +: 8] = ($urandom_range(3) == 0) ? 8'h00 : k[8*b +: 8];
        end
        if (nb < 8)
            k[8*nb +: 8] = 8'h00;
        return k;
    endfunction

    task automatic add_req(kind_t kd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        req_t r;
        r.kind = kd;
        r.key = k;
        r.value = v;
        pending_req.push_back(r);
    endtask

    task automatic drain();
        while (pending_req.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_capacity(logic [LOG2_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tbl_log2 = v;
        clear_tbl();
    endtask

    task automatic random_phase(int count);
        logic [KEY_W-1:0] k;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (used_keys.size() == 0 || $urandom_range(99) < 35)
            begin
                k = fresh_key();
                if (used_keys.size() < 400)
                    used_keys.push_back(k);
            end
            else
            begin
                k = used_keys[$urandom_range(used_keys.size() - 1)];
                if ($urandom_range(9) == 0)
                    k[63:56] = 8'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 45)
                add_req(KIND_INSERT, k, $urandom);
            else if (pick < 70)
                add_req(KIND_LOOKUP, k, $urandom);
            else if (pick < 95)
                add_req(KIND_REMOVE, k, $urandom);
            else
                add_req(KIND_SPARE, k, $urandom);
        end
    endtask

    initial
    begin
        logic [LOG2_W-1:0] caps [8];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        watch = 0;
        idle_on = 1'b1;
        hold_send = 1'b0;
        tbl_log2 = 4;
        clear_tbl();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        add_req(KIND_LOOKUP, 64'h0, 32'h0);
        add_req(KIND_INSERT, 64'h0, 32'hffffffff);
        add_req(KIND_LOOKUP, 64'h0012, 32'h0);
        add_req(KIND_INSERT, 64'hffffffffffffffff, 32'h12345678);
        add_req(KIND_INSERT, 64'hffffffffffffffff, 32'h0);
        add_req(KIND_LOOKUP, 64'hffffffffffffffff, 32'h0);
        add_req(KIND_INSERT, 64'h1122334400667788, 32'haaaa5555);
        add_req(KIND_SPARE, 64'hff11223344, 32'h0);
        add_req(KIND_REMOVE, 64'h0, 32'h0);
        add_req(KIND_REMOVE, 64'h0, 32'h0);
        add_req(KIND_INSERT, 64'h0, 32'h5555aaaa);
        add_req(KIND_REMOVE, 64'h5a, 32'h0);
        for (int i = 1; i <= 13; i++)
            add_req(KIND_INSERT, {56'd0, 8'(i)}, i);
        drain();

        caps = '{4'd0, 4'd15, 4'd10, 4'd5, 4'd4, 4'd3, 4'd6, 4'd4};
        for (int p = 0; p < 8; p++)
        begin
            set_capacity(caps[p]);
            used_keys.delete();
            idle_on = (p != 2);
            random_phase(150);
            if (p == 3)
            begin
                drain();
                hold_send = 1'b1;
                drain();
                hold_send = 1'b0;
                random_phase(30);
            end
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
